/* hdl/auto_gain_ranging_top_assert.svh */
// ----------------------------------------------------------------------------
// auto gain ranging assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AUTO_GAIN_RANGING_TOP_ASSERT_SVH
`define AUTO_GAIN_RANGING_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define AGR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, quiet while reset is held
`define AGR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/agr_pkg.sv */
// ----------------------------------------------------------------------------
// agr_pkg
// types and constants of the auto gain ranging block
// ----------------------------------------------------------------------------
package agr_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_GAIN_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_REAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_IMAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_REAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_IMAG = 2'd3;

  // closeness windows for component detection
  localparam logic signed [DATA_W:0] Z_CLOSE  = 33'sd15000;
  localparam logic signed [DATA_W:0] VI_CLOSE = 33'sd100;

  // one measurement, z_real in the lowest bits
  typedef struct packed {
    logic signed [DATA_W-1:0] i_imag;
    logic signed [DATA_W-1:0] i_real;
    logic signed [DATA_W-1:0] v_imag;
    logic signed [DATA_W-1:0] v_real;
    logic signed [DATA_W-1:0] z_imag;
    logic signed [DATA_W-1:0] z_real;
  } meas_t;

  // one result, voltage_gain in the lowest bits
  typedef struct packed {
    logic                  settled;
    logic                  measuring;
    logic [OUT_GAIN_W-1:0] current_gain;
    logic [OUT_GAIN_W-1:0] voltage_gain;
  } result_t;

  // per-channel search status
  typedef struct packed {
    logic en;
    logic done;
  } chan_ctl_t;

  // |a - b| < lim at full width
  function automatic logic near(input logic signed [DATA_W-1:0] a,
                                input logic signed [DATA_W-1:0] b,
                                input logic signed [DATA_W:0]   lim);
    logic signed [DATA_W:0] d;
    d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    return (d < lim) && (d > -lim);
  endfunction

endpackage

/* hdl/agr_channel.sv */
// ----------------------------------------------------------------------------
// agr_channel
// one search step of a single amplifier channel
// ----------------------------------------------------------------------------
module agr_channel #(
  parameter int GAIN_W   = 3,
  parameter int MAX_GAIN = 7,
  parameter int WAVES    = 4,
  parameter int LIM_W    = 35
) (
  input  agr_pkg::chan_ctl_t             ctl_i,
  input  logic signed [agr_pkg::DATA_W-1:0] re_i,
  input  logic signed [agr_pkg::DATA_W-1:0] im_i,
  input  logic [agr_pkg::DATA_W-1:0]     lim_re_i,
  input  logic [agr_pkg::DATA_W-1:0]     lim_im_i,
  input  logic [GAIN_W-1:0]              gain_i,
  output logic [GAIN_W-1:0]              gain_o,
  output logic                           done_o
);
  import agr_pkg::*;

  logic [DATA_W-1:0] mag_re, mag_im;
  logic [LIM_W-1:0]  top_re, top_im;
  logic              over;

  // two's complement magnitude, most negative value maps to 2^31
  assign mag_re = re_i[DATA_W-1] ? (~re_i + 1'b1) : re_i;
  assign mag_im = im_i[DATA_W-1] ? (~im_i + 1'b1) : im_i;

  assign top_re = LIM_W'(lim_re_i) * LIM_W'(WAVES);
  assign top_im = LIM_W'(lim_im_i) * LIM_W'(WAVES);

  assign over = (LIM_W'(mag_re) > top_re) || (LIM_W'(mag_im) > top_im);

  always_comb begin
    gain_o = gain_i;
    done_o = ctl_i.done;
    if (ctl_i.en && !ctl_i.done) begin
      if (over) begin
        if (gain_i != '0) gain_o = gain_i - 1'b1;
        done_o = 1'b1;
      end else if (gain_i < GAIN_W'(MAX_GAIN)) begin
        gain_o = gain_i + 1'b1;
      end else begin
        done_o = 1'b1;
      end
    end
  end

endmodule

/* hdl/auto_gain_ranging_top.sv */
// ----------------------------------------------------------------------------
// auto_gain_ranging_top
// gain search for an impedance meter: detects a new component and steps
// the voltage and current amplifier gains until both channels settle
// ----------------------------------------------------------------------------
// structure: an input register, then a result register; the search step
//   sits between them
// throughput: 1 request per cycle while out_tready is high; a stalled
//   result register holds the input stage and the search state
// reset: synchronous active-low rst_n clears limits, previous measurement,
//   gains, search flags and both valid registers; no clearing pass
module auto_gain_ranging_top #(
  parameter int MAX_GAIN_INDEX = 7,
  parameter int WAVES_SUMMED   = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [agr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agr_pkg::DATA_W-1:0]     cfg_wdata,
  // measurement requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // z_real[31:0], z_imag[63:32], v_real[95:64], v_imag[127:96],
  // i_real[159:128], i_imag[191:160]
  input  logic [6*agr_pkg::DATA_W-1:0]   in_tdata,
  // gain results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // voltage_gain[2:0], current_gain[5:3], measuring[6], settled[7]
  output logic [7:0]                     out_tdata
);
  import agr_pkg::*;

  // gain counter must hold MAX_GAIN_INDEX itself
  localparam int GAIN_W = (MAX_GAIN_INDEX > 1) ? $clog2(MAX_GAIN_INDEX + 1) : 1;
  // limit times number of summed waveforms, never wraps
  localparam int LIM_W  = DATA_W + $clog2(WAVES_SUMMED + 1);

  // calibrated limits
  logic [DATA_W-1:0] volt_real_lim_r, volt_imag_lim_r;
  logic [DATA_W-1:0] curr_real_lim_r, curr_imag_lim_r;

  // input stage
  logic  in_valid_r;
  meas_t in_data_r;

  // search state
  meas_t             prev_r;
  logic              active_r, volt_done_r, curr_done_r;
  logic [GAIN_W-1:0] volt_gain_r, curr_gain_r;
  logic              active_nxt, volt_done_nxt, curr_done_nxt;
  logic [GAIN_W-1:0] volt_gain_nxt, curr_gain_nxt;

  // result stage
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;

  logic              advance;
  logic              detect, act, done_now;
  logic [GAIN_W-1:0] volt_gain_start, curr_gain_start;
  chan_ctl_t         volt_ctl, curr_ctl;

  // the step moves when the input stage holds a request and the result
  // register is empty or being drained this cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // ------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_real_lim_r <= '0;
      volt_imag_lim_r <= '0;
      curr_real_lim_r <= '0;
      curr_imag_lim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLT_REAL: volt_real_lim_r <= cfg_wdata;
        REG_VOLT_IMAG: volt_imag_lim_r <= cfg_wdata;
        REG_CURR_REAL: curr_real_lim_r <= cfg_wdata;
        REG_CURR_IMAG: curr_imag_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata;
  end

  // ------------------------------------------------------------------
  // detection and search step
  // ------------------------------------------------------------------
  // new component: idle, impedance steady, and voltage or current steady
  assign detect = !active_r
               && near(in_data_r.z_real, prev_r.z_real, Z_CLOSE)
               && near(in_data_r.z_imag, prev_r.z_imag, Z_CLOSE)
               && ((near(in_data_r.v_real, prev_r.v_real, VI_CLOSE)
                    && near(in_data_r.v_imag, prev_r.v_imag, VI_CLOSE))
                || (near(in_data_r.i_real, prev_r.i_real, VI_CLOSE)
                    && near(in_data_r.i_imag, prev_r.i_imag, VI_CLOSE)));

  assign act             = active_r || detect;
  assign volt_gain_start = detect ? '0 : volt_gain_r;
  assign curr_gain_start = detect ? '0 : curr_gain_r;
  assign volt_ctl        = '{en: act, done: detect ? 1'b0 : volt_done_r};
  assign curr_ctl        = '{en: act, done: detect ? 1'b0 : curr_done_r};

  agr_channel #(
    .GAIN_W  (GAIN_W),
    .MAX_GAIN(MAX_GAIN_INDEX),
    .WAVES   (WAVES_SUMMED),
    .LIM_W   (LIM_W)
  ) u_volt (
    .ctl_i   (volt_ctl),
    .re_i    (in_data_r.v_real),
    .im_i    (in_data_r.v_imag),
    .lim_re_i(volt_real_lim_r),
    .lim_im_i(volt_imag_lim_r),
    .gain_i  (volt_gain_start),
    .gain_o  (volt_gain_nxt),
    .done_o  (volt_done_nxt)
  );

  agr_channel #(
    .GAIN_W  (GAIN_W),
    .MAX_GAIN(MAX_GAIN_INDEX),
    .WAVES   (WAVES_SUMMED),
    .LIM_W   (LIM_W)
  ) u_curr (
    .ctl_i   (curr_ctl),
    .re_i    (in_data_r.i_real),
    .im_i    (in_data_r.i_imag),
    .lim_re_i(curr_real_lim_r),
    .lim_im_i(curr_imag_lim_r),
    .gain_i  (curr_gain_start),
    .gain_o  (curr_gain_nxt),
    .done_o  (curr_done_nxt)
  );

  // search ends once both channels have settled
  assign done_now   = act && volt_done_nxt && curr_done_nxt;
  assign active_nxt = act && !done_now;

  always_comb begin
    out_data_nxt.voltage_gain = OUT_GAIN_W'(volt_gain_nxt);
    out_data_nxt.current_gain = OUT_GAIN_W'(curr_gain_nxt);
    out_data_nxt.measuring    = active_nxt;
    out_data_nxt.settled      = done_now;
    out_valid_nxt             = advance || (out_valid_r && !out_tready);
  end

  // ------------------------------------------------------------------
  // state and result registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      active_r    <= 1'b0;
      volt_done_r <= 1'b0;
      curr_done_r <= 1'b0;
      volt_gain_r <= '0;
      curr_gain_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        // previous measurement is always kept
        prev_r      <= in_data_r;
        active_r    <= active_nxt;
        volt_done_r <= volt_done_nxt;
        curr_done_r <= curr_done_nxt;
        volt_gain_r <= volt_gain_nxt;
        curr_gain_r <= curr_gain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/agr_checker.sv */
// ----------------------------------------------------------------------------
// agr_checker
// port-level checks of the auto gain ranging block, bound to the top level
// ----------------------------------------------------------------------------
`include "auto_gain_ranging_top_assert.svh"

module agr_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  // a stalled result holds
  `AGR_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata))
  // a settling step ends the search
  `AGR_ASSERT_IMP(a_settled_ends, clk, rst_n, out_tvalid && out_tdata[7], !out_tdata[6])
  // an empty result register never blocks requests
  `AGR_ASSERT_IMP(a_ready_empty, clk, rst_n, !out_tvalid, in_tready)
  // a request taken with the output free: out_tvalid or in_tready follows
  `AGR_ASSERT_IMP(a_latency, clk, rst_n,
                  $past(in_tvalid && in_tready && !out_tvalid, 1)
                  && $past(!out_tvalid || out_tready, 1)
                  && !$past(out_tvalid, 2) && $past(rst_n, 2),
                  out_tvalid || in_tready)

endmodule

bind auto_gain_ranging_top agr_port_checker u_agr_checker (.*);
